[design/gcov_pkg.sv]
// shared widths, entry maps, payload types and rotation helpers for the
// gaussian covariance pipeline; no dependencies
package gcov_pkg;

	localparam int SW    = 24;                 // scale, unsigned q8.16
	localparam int QW    = 16;                 // quaternion part, signed q1.15
	localparam int CW    = 48;                 // covariance entry, signed q24.24
	localparam int QPW   = 2 * QW;             // quaternion product
	localparam int RW    = QPW + 2;            // rotation entry, units of 2^-30
	localparam int RFRAC = 2 * (QW - 1);
	localparam int AW    = RW + SW;            // scaled rotation entry, units of 2^-46
	localparam int ALO   = AW / 2;             // low half of a split operand
	localparam int AHI   = AW - ALO;           // signed high half
	localparam int PPW   = 2 * AHI;            // signed partial product
	localparam int LLW   = 2 * ALO;            // low by low partial product
	localparam int SUMW  = 2 * AW + 4;         // exact sum of three products
	localparam int SFRAC = 16;                 // fraction bits of a scale
	localparam int CFRAC = 24;                 // fraction bits of a result
	localparam int SHIFT = 2 * (RFRAC + SFRAC) - CFRAC;
	localparam int RND_POS = SHIFT - 1;

	localparam int NDIM  = 3;
	localparam int NENT  = 6;
	localparam int NPROD = NENT * NDIM;

	// row and column of each upper-triangle entry: xx xy xz yy yz zz
	localparam int ENT_ROW [NENT] = '{0, 0, 0, 1, 1, 2};
	localparam int ENT_COL [NENT] = '{0, 1, 2, 1, 2, 2};

	localparam logic signed [RW:0]     ROT_ONE = (RW + 1)'(1) <<< RFRAC;
	localparam logic [SUMW-1:0]        RND_ADD = SUMW'(1) << RND_POS;
	localparam logic signed [CW-1:0]   POS_MAX = {1'b0, {(CW - 1){1'b1}}};
	localparam logic signed [CW-1:0]   NEG_MIN = {1'b1, {(CW - 1){1'b0}}};

	typedef struct packed {
		logic [SW-1:0]        scale_x;
		logic [SW-1:0]        scale_y;
		logic [SW-1:0]        scale_z;
		logic signed [QW-1:0] quat_real;
		logic signed [QW-1:0] quat_i;
		logic signed [QW-1:0] quat_j;
		logic signed [QW-1:0] quat_k;
	} gauss_t;

	typedef struct packed {
		logic signed [CW-1:0] cov_xx;
		logic signed [CW-1:0] cov_xy;
		logic signed [CW-1:0] cov_xz;
		logic signed [CW-1:0] cov_yy;
		logic signed [CW-1:0] cov_yz;
		logic signed [CW-1:0] cov_zz;
	} cov_t;

	typedef struct packed {
		logic [NDIM-1:0][SW-1:0]        scale;
		logic [NDIM*NDIM-1:0][RW-1:0]   rot;
	} rot_t;

	typedef logic [NDIM*NDIM-1:0][AW-1:0] amat_t;
	typedef logic [NENT-1:0][SUMW-1:0]    csum_t;

	// 1 - 2(a + b)
	function automatic logic [RW-1:0] rot_diag(input logic signed [QPW-1:0] a,
			input logic signed [QPW-1:0] b);
		logic signed [RW:0] t;
		t = ROT_ONE - (((RW + 1)'(a) + (RW + 1)'(b)) <<< 1);
		return t[RW-1:0];
	endfunction

	// 2(a + b) or 2(a - b); with every part at -1 this reaches 2^32
	function automatic logic [RW-1:0] rot_offd(input logic signed [QPW-1:0] a,
			input logic signed [QPW-1:0] b, input logic sub);
		logic signed [RW:0] t;
		if (sub) begin
			t = (RW + 1)'(a) - (RW + 1)'(b);
		end else begin
			t = (RW + 1)'(a) + (RW + 1)'(b);
		end
		t = t <<< 1;
		return t[RW-1:0];
	endfunction

endpackage

[design/gcov_in_if.sv]
// request channel carrying one gaussian's scales and quaternion
// depends on gcov_pkg
interface gcov_in_if;
	logic            valid;
	logic            ready;
	gcov_pkg::gauss_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/gcov_out_if.sv]
// result channel carrying the six upper-triangle covariance entries
// depends on gcov_pkg
interface gcov_out_if;
	logic          valid;
	logic          ready;
	gcov_pkg::cov_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/gcov_rot.sv]
// stages 1 and 2: quaternion products, then the rotation matrix entries
// depends on gcov_pkg
module gcov_rot (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  gcov_pkg::gauss_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output gcov_pkg::rot_t   out_data
);
	import gcov_pkg::*;

	logic valid_s1, valid_s2;
	logic en_s1, en_s2;

	logic signed [QPW-1:0] p_ii_s1, p_jj_s1, p_kk_s1;
	logic signed [QPW-1:0] p_ij_s1, p_ik_s1, p_jk_s1;
	logic signed [QPW-1:0] p_ri_s1, p_rj_s1, p_rk_s1;
	logic [NDIM-1:0][SW-1:0] scale_s1;

	rot_t rot_c, rot_s2;

	assign en_s2    = !valid_s2 || out_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign in_ready = en_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			p_ii_s1     <= in_data.quat_i * in_data.quat_i;
			p_jj_s1     <= in_data.quat_j * in_data.quat_j;
			p_kk_s1     <= in_data.quat_k * in_data.quat_k;
			p_ij_s1     <= in_data.quat_i * in_data.quat_j;
			p_ik_s1     <= in_data.quat_i * in_data.quat_k;
			p_jk_s1     <= in_data.quat_j * in_data.quat_k;
			p_ri_s1     <= in_data.quat_real * in_data.quat_i;
			p_rj_s1     <= in_data.quat_real * in_data.quat_j;
			p_rk_s1     <= in_data.quat_real * in_data.quat_k;
			scale_s1[0] <= in_data.scale_x;
			scale_s1[1] <= in_data.scale_y;
			scale_s1[2] <= in_data.scale_z;
		end
	end

	always_comb begin
		rot_c.scale  = scale_s1;
		rot_c.rot[0] = rot_diag(p_jj_s1, p_kk_s1);
		rot_c.rot[1] = rot_offd(p_ij_s1, p_rk_s1, 1'b1);
		rot_c.rot[2] = rot_offd(p_ik_s1, p_rj_s1, 1'b0);
		rot_c.rot[3] = rot_offd(p_ij_s1, p_rk_s1, 1'b0);
		rot_c.rot[4] = rot_diag(p_ii_s1, p_kk_s1);
		rot_c.rot[5] = rot_offd(p_jk_s1, p_ri_s1, 1'b1);
		rot_c.rot[6] = rot_offd(p_ik_s1, p_rj_s1, 1'b1);
		rot_c.rot[7] = rot_offd(p_jk_s1, p_ri_s1, 1'b0);
		rot_c.rot[8] = rot_diag(p_ii_s1, p_jj_s1);
	end

	always_ff @(posedge clk) begin
		if (en_s2 && valid_s1) begin
			rot_s2 <= rot_c;
		end
	end

	assign out_valid = valid_s2;
	assign out_data  = rot_s2;
endmodule

[design/gcov_scale.sv]
// stage 3: each rotation entry times the scale of its column
// depends on gcov_pkg
module gcov_scale (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gcov_pkg::rot_t  in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output gcov_pkg::amat_t out_data
);
	import gcov_pkg::*;

	logic  valid_s3;
	logic  en_s3;
	amat_t amat_c, amat_s3;

	assign en_s3    = !valid_s3 || out_ready;
	assign in_ready = en_s3;

	always_comb begin
		logic signed [AW:0] m;
		m = '0;
		for (int r = 0; r < NDIM; r++) begin
			for (int n = 0; n < NDIM; n++) begin
				m = $signed(in_data.rot[r*NDIM+n]) * $signed({1'b0, in_data.scale[n]});
				amat_c[r*NDIM+n] = m[AW-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en_s3) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			amat_s3 <= amat_c;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = amat_s3;
endmodule

[design/gcov_outer.sv]
// stages 4 to 6: split products of scaled rotation rows, their recombination
// and the three-term sum of each covariance entry; depends on gcov_pkg
module gcov_outer (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gcov_pkg::amat_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output gcov_pkg::csum_t out_data
);
	import gcov_pkg::*;

	logic valid_s4, valid_s5, valid_s6;
	logic en_s4, en_s5, en_s6;

	logic signed [PPW-1:0] hh_c [NPROD];
	logic signed [PPW-1:0] hl_c [NPROD];
	logic signed [PPW-1:0] lh_c [NPROD];
	logic [LLW-1:0]        ll_c [NPROD];
	logic signed [PPW-1:0] hh_s4 [NPROD];
	logic signed [PPW-1:0] hl_s4 [NPROD];
	logic signed [PPW-1:0] lh_s4 [NPROD];
	logic [LLW-1:0]        ll_s4 [NPROD];

	logic signed [SUMW-1:0] prod_c [NPROD];
	logic signed [SUMW-1:0] prod_s5 [NPROD];

	csum_t sum_c, sum_s6;

	assign en_s6    = !valid_s6 || out_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign en_s4    = !valid_s4 || en_s5;
	assign in_ready = en_s4;

	// each operand is split into a signed high and an unsigned low half
	always_comb begin
		logic [AW-1:0] a, b;
		for (int e = 0; e < NENT; e++) begin
			for (int n = 0; n < NDIM; n++) begin
				a = in_data[ENT_ROW[e]*NDIM+n];
				b = in_data[ENT_COL[e]*NDIM+n];
				hh_c[e*NDIM+n] = $signed(a[AW-1:ALO]) * $signed(b[AW-1:ALO]);
				hl_c[e*NDIM+n] = $signed(a[AW-1:ALO]) * $signed({1'b0, b[ALO-1:0]});
				lh_c[e*NDIM+n] = $signed({1'b0, a[ALO-1:0]}) * $signed(b[AW-1:ALO]);
				ll_c[e*NDIM+n] = a[ALO-1:0] * b[ALO-1:0];
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NPROD; k++) begin
			prod_c[k] = (SUMW'(hh_s4[k]) <<< LLW)
				+ ((SUMW'(hl_s4[k]) + SUMW'(lh_s4[k])) <<< ALO)
				+ SUMW'($signed({1'b0, ll_s4[k]}));
		end
	end

	always_comb begin
		for (int e = 0; e < NENT; e++) begin
			sum_c[e] = prod_s5[e*NDIM] + prod_s5[e*NDIM+1] + prod_s5[e*NDIM+2];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s4) begin
				valid_s4 <= in_valid;
			end
			if (en_s5) begin
				valid_s5 <= valid_s4;
			end
			if (en_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s4 && in_valid) begin
			hh_s4 <= hh_c;
			hl_s4 <= hl_c;
			lh_s4 <= lh_c;
			ll_s4 <= ll_c;
		end
		if (en_s5 && valid_s4) begin
			prod_s5 <= prod_c;
		end
		if (en_s6 && valid_s5) begin
			sum_s6 <= sum_c;
		end
	end

	assign out_valid = valid_s6;
	assign out_data  = sum_s6;
endmodule

[design/gcov_round.sv]
// stage 7: round half up to q24.24, saturate, and hold the result for the sink
// depends on gcov_pkg
module gcov_round (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  gcov_pkg::csum_t in_data,
	output logic            out_valid,
	input  logic            out_ready,
	output gcov_pkg::cov_t  out_data
);
	import gcov_pkg::*;

	logic valid_s7;
	logic en_s7;
	logic signed [CW-1:0] res_c [NENT];
	cov_t cov_c, cov_s7;

	assign en_s7    = !valid_s7 || out_ready;
	assign in_ready = en_s7;

	always_comb begin
		logic [SUMW-1:0]       t;
		logic [SUMW-SHIFT-1:0] q;
		for (int e = 0; e < NENT; e++) begin
			t = in_data[e] + RND_ADD;
			q = t[SUMW-1:SHIFT];
			// the bits above the result must all copy its sign
			if (q[SUMW-SHIFT-1:CW-1] == '0 || q[SUMW-SHIFT-1:CW-1] == '1) begin
				res_c[e] = q[CW-1:0];
			end else if (q[SUMW-SHIFT-1]) begin
				res_c[e] = NEG_MIN;
			end else begin
				res_c[e] = POS_MAX;
			end
		end
		cov_c.cov_xx = res_c[0];
		cov_c.cov_xy = res_c[1];
		cov_c.cov_xz = res_c[2];
		cov_c.cov_yy = res_c[3];
		cov_c.cov_yz = res_c[4];
		cov_c.cov_zz = res_c[5];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else if (en_s7) begin
			valid_s7 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_s7 && in_valid) begin
			cov_s7 <= cov_c;
		end
	end

	assign out_valid = valid_s7;
	assign out_data  = cov_s7;
endmodule

[design/gaussian_covariance_from_scale_rotation_core.sv]
// top level of the gaussian covariance pipeline
// depends on gcov_pkg, gcov_in_if, gcov_out_if and the gcov stage modules
//
// Takes one gaussian per request on gauss: three unsigned q8.16 scales and a
// quaternion in signed q1.15, real part first, used as given. Returns on cov
// the six upper-triangle entries of R * diag(s^2) * R^T in signed q24.24,
// rounded half up and saturated.
// Both channels use valid/ready; a request moves when both are high.
// The pipeline has seven register stages: quaternion products, rotation
// entries, scale multiply, split partial products, product recombination,
// three-term sum, round and saturate. One request per cycle is taken
// steadily while cov.ready stays high.
// Each stage has its own valid bit and holds when the stage after it is full
// and stalled, so empty stages keep filling while cov.ready is low; gauss.ready
// falls only once all seven stages hold data.
// Reset clears every valid bit; the data registers are left as they are.
module gaussian_covariance_from_scale_rotation_core (
	input logic        clk,
	input logic        arst_n,
	gcov_in_if.sink    gauss,
	gcov_out_if.source cov
);
	import gcov_pkg::*;

	logic  rot_valid, rot_ready;
	rot_t  rot_data;
	logic  amat_valid, amat_ready;
	amat_t amat_data;
	logic  sum_valid, sum_ready;
	csum_t sum_data;

	gcov_rot u_rot (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (gauss.valid),
		.in_ready  (gauss.ready),
		.in_data   (gauss.data),
		.out_valid (rot_valid),
		.out_ready (rot_ready),
		.out_data  (rot_data)
	);

	gcov_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (rot_valid),
		.in_ready  (rot_ready),
		.in_data   (rot_data),
		.out_valid (amat_valid),
		.out_ready (amat_ready),
		.out_data  (amat_data)
	);

	gcov_outer u_outer (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (amat_valid),
		.in_ready  (amat_ready),
		.in_data   (amat_data),
		.out_valid (sum_valid),
		.out_ready (sum_ready),
		.out_data  (sum_data)
	);

	gcov_round u_round (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sum_valid),
		.in_ready  (sum_ready),
		.in_data   (sum_data),
		.out_valid (cov.valid),
		.out_ready (cov.ready),
		.out_data  (cov.data)
	);
endmodule
